[design/msort_pkg.sv]
`default_nettype none

package msort_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int ADDR_W    = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int SUM_W     = CNT_W + 1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PRIME,
    ST_MERGE,
    ST_RD,
    ST_LD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 we_a;
    logic                 we_b;
    logic [ADDR_W-1:0]    waddr;
    logic [KEY_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]    raddr0;
    logic [ADDR_W-1:0]    raddr1;
  } ram_req_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] a0;
    logic [KEY_WIDTH-1:0] a1;
    logic [KEY_WIDTH-1:0] b0;
    logic [KEY_WIDTH-1:0] b1;
  } ram_rsp_t;

endpackage

`default_nettype wire

[design/msort_ram.sv]
`default_nettype none

module msort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

[design/msort_ctrl.sv]
`default_nettype none

module msort_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  input  wire logic                            descending,
  input  wire logic                            in_valid,
  input  wire logic [msort_pkg::KEY_WIDTH-1:0] key,
  input  wire logic                            last_in,
  output logic                                 in_stall,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [msort_pkg::KEY_WIDTH-1:0] sorted_key,
  output logic                                 last_out,
  output logic                                 overflow,
  output msort_pkg::ram_req_t                  req,
  input  msort_pkg::ram_rsp_t                  rsp
);

  import msort_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic               dropped, dropped_next;
  logic               desc;
  logic [CNT_W-1:0]   i, i_next;
  logic [CNT_W-1:0]   j, j_next;
  logic [CNT_W-1:0]   k, k_next;
  logic [CNT_W-1:0]   mid, mid_next;
  logic [CNT_W-1:0]   hi, hi_next;
  logic [CNT_W-1:0]   w, w_next;
  logic               src, src_next;
  logic [ADDR_W-1:0]  o, o_next;

  logic [KEY_WIDTH-1:0] q_l, q_r;
  logic                 right_first, take_r;
  logic                 full, in_acc, out_acc, emit_last;
  logic [CNT_W-1:0]     n_last;
  logic [SUM_W-1:0]     hi_w, hi_2w, w2, w4, n_ext;
  logic [CNT_W-1:0]     mid_grp, hi_grp, mid_pass, hi_pass;

  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && (state == ST_LOAD);
  assign out_acc  = out_valid && !out_stall;
  assign full     = (cnt == CNT_W'(MAX_KEYS));
  assign n_last   = full ? cnt : cnt + CNT_W'(1);
  assign emit_last = ({1'b0, o} == cnt - CNT_W'(1));

  assign q_l = src ? rsp.b0 : rsp.a0;
  assign q_r = src ? rsp.b1 : rsp.a1;
  assign right_first = desc ? (q_r > q_l) : (q_l > q_r);
  assign take_r = (i >= mid) || ((j < hi) && right_first);

  assign n_ext    = {1'b0, cnt};
  assign hi_w     = {1'b0, hi} + {1'b0, w};
  assign hi_2w    = {1'b0, hi} + ({1'b0, w} << 1);
  assign w2       = {1'b0, w} << 1;
  assign w4       = {1'b0, w} << 2;
  assign mid_grp  = (hi_w  > n_ext) ? cnt : hi_w[CNT_W-1:0];
  assign hi_grp   = (hi_2w > n_ext) ? cnt : hi_2w[CNT_W-1:0];
  assign mid_pass = (w2    > n_ext) ? cnt : w2[CNT_W-1:0];
  assign hi_pass  = (w4    > n_ext) ? cnt : w4[CNT_W-1:0];

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    dropped_next = dropped;
    i_next       = i;
    j_next       = j;
    k_next       = k;
    mid_next     = mid;
    hi_next      = hi;
    w_next       = w;
    src_next     = src;
    o_next       = o;
    req          = '0;
    req.wdata    = key;
    case (state)
      ST_LOAD: begin
        req.waddr = cnt[ADDR_W-1:0];
        if (in_acc) begin
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            req.we_a = 1'b1;
            cnt_next = cnt + CNT_W'(1);
          end
          if (last_in) begin
            src_next = 1'b0;
            o_next   = '0;
            if (n_last > CNT_W'(1)) begin
              w_next     = CNT_W'(1);
              i_next     = '0;
              k_next     = '0;
              mid_next   = CNT_W'(1);
              j_next     = CNT_W'(1);
              hi_next    = CNT_W'(2);
              state_next = ST_PRIME;
            end else begin
              state_next = ST_RD;
            end
          end
        end
      end
      ST_PRIME: begin
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        req.we_a  = src;
        req.we_b  = !src;
        req.waddr = k[ADDR_W-1:0];
        req.wdata = take_r ? q_r : q_l;
        if (take_r) begin
          j_next = j + CNT_W'(1);
        end else begin
          i_next = i + CNT_W'(1);
        end
        k_next = k + CNT_W'(1);
        if (k_next == cnt) begin
          src_next = !src;
          if (w2 >= n_ext) begin
            o_next     = '0;
            state_next = ST_RD;
          end else begin
            w_next     = w2[CNT_W-1:0];
            i_next     = '0;
            k_next     = '0;
            mid_next   = mid_pass;
            j_next     = mid_pass;
            hi_next    = hi_pass;
            state_next = ST_PRIME;
          end
        end else if (k_next == hi) begin
          i_next   = hi;
          mid_next = mid_grp;
          j_next   = mid_grp;
          hi_next  = hi_grp;
        end
      end
      ST_RD: begin
        state_next = ST_LD;
      end
      ST_LD: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (last_out) begin
            cnt_next     = '0;
            dropped_next = 1'b0;
            state_next   = ST_LOAD;
          end else begin
            o_next     = o + ADDR_W'(1);
            state_next = ST_RD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
    req.raddr0 = (state == ST_RD) ? o_next : i_next[ADDR_W-1:0];
    req.raddr1 = j_next[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      cnt       <= '0;
      dropped   <= 1'b0;
      desc      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      dropped <= dropped_next;
      if (cfg_valid) begin
        desc <= descending;
      end
      if (state == ST_LD) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i   <= i_next;
    j   <= j_next;
    k   <= k_next;
    mid <= mid_next;
    hi  <= hi_next;
    w   <= w_next;
    src <= src_next;
    o   <= o_next;
    if (state == ST_LD) begin
      sorted_key <= q_l;
      last_out   <= emit_last;
      overflow   <= dropped;
    end
  end

endmodule

`default_nettype wire

[design/merge_sorter_core.sv]
`default_nettype none

// Stable merge sorter for up to 64 unsigned 32-bit keys. Keys load one per
// cycle until an item with last_in set; keys past 64 are dropped and every
// result of that set then carries overflow. The set is sorted in two
// ping-pong buffer memories by bottom-up merge passes, one element merged per
// cycle, in ceil(log2 n) passes for a set of n keys. Results then leave one
// at a time, each read after the one before is taken, the final one marked
// with last_out; no key is taken from the sort's start until the last result
// is taken. Equal keys keep their arrival order. The user is to write the
// descending register (0 ascending, 1 descending) only while idle; unenforced.

module merge_sorter_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic                            descending,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [msort_pkg::KEY_WIDTH-1:0] key,
  input  wire logic                            last_in,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [msort_pkg::KEY_WIDTH-1:0] sorted_key,
  output logic                                 last_out,
  output logic                                 overflow
);

  import msort_pkg::*;

  ram_req_t req;
  ram_rsp_t rsp;

  assign cfg_ready = 1'b1;

  msort_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .descending (descending),
    .in_valid   (in_valid),
    .key        (key),
    .last_in    (last_in),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sorted_key (sorted_key),
    .last_out   (last_out),
    .overflow   (overflow),
    .req        (req),
    .rsp        (rsp)
  );

  msort_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (MAX_KEYS)
  ) u_buf_a (
    .clk    (clk),
    .we     (req.we_a),
    .waddr  (req.waddr),
    .wdata  (req.wdata),
    .raddr0 (req.raddr0),
    .raddr1 (req.raddr1),
    .rdata0 (rsp.a0),
    .rdata1 (rsp.a1)
  );

  msort_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (MAX_KEYS)
  ) u_buf_b (
    .clk    (clk),
    .we     (req.we_b),
    .waddr  (req.waddr),
    .wdata  (req.wdata),
    .raddr0 (req.raddr0),
    .raddr1 (req.raddr1),
    .rdata0 (rsp.b0),
    .rdata1 (rsp.b1)
  );

endmodule

`default_nettype wire

[design/msort_check.sv]
`default_nettype none

module msort_check (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            cfg_valid,
  input wire logic                            cfg_ready,
  input wire logic                            descending,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [msort_pkg::KEY_WIDTH-1:0] sorted_key,
  input wire logic                            last_out,
  input wire logic                            overflow
);

  import msort_pkg::*;

  logic                 desc_seen;
  logic                 prev_valid;
  logic [KEY_WIDTH-1:0] prev_key;
  logic                 out_acc;

  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_seen  <= 1'b0;
      prev_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        desc_seen <= descending;
      end
      if (out_acc) begin
        prev_valid <= !last_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_key <= sorted_key;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sorted_key) && $stable(last_out)
      && $stable(overflow))
    else $error("output item changed while stalled");

  a_no_load_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  a_set_end: assert property (@(posedge clk) disable iff (rst)
    out_acc && last_out |=> !out_valid)
    else $error("result after final item of set");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_acc && prev_valid |->
      (desc_seen ? (sorted_key <= prev_key) : (sorted_key >= prev_key)))
    else $error("results out of order");

endmodule

bind merge_sorter_core msort_check u_check (.*);

`default_nettype wire
